@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
// expects clk and rst_n in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only out of reset
`define DPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define DPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/dps_pkg.sv @@
// shared constants and codes for the darcy pressure sor solver
// no dependencies
package dps_pkg;

  localparam int ADDR_W     = 12;
  localparam int NODE_DEPTH = 4096;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_CONV    = 2'd0;
  localparam logic [1:0] ST_NOCONV  = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELLS_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASPECT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELAX    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIM = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BND_P    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TUM_P    = 3'd7;

endpackage

@@ hw/rtl/dps_if.sv @@
// valid/ready channel interfaces for solver commands and results
// depends on dps_pkg
interface dps_in_if import dps_pkg::*;;
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] node_index;
  logic [31:0]       conductivity;
  logic              tumor_flag;

  modport source (output valid, opcode, node_index, conductivity, tumor_flag, input ready);
  modport sink   (input valid, opcode, node_index, conductivity, tumor_flag, output ready);
endinterface

interface dps_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pressure;
  logic [1:0]         status;
  logic [15:0]        sweeps_used;
  logic [31:0]        max_defect;

  modport source (output valid, pressure, status, sweeps_used, max_defect, input ready);
  modport sink   (input valid, pressure, status, sweeps_used, max_defect, output ready);
endinterface

@@ hw/rtl/dps_ram.sv @@
// generic single write, single read ram with registered read data
// no dependencies
module dps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;
endmodule

@@ hw/rtl/darcy_pressure_sor_solver.sv @@
// top level of the darcy pressure sor solver: sequencer, shared multiplier and divider
// depends on dps_pkg, dps_if, dps_ram and assert_macros.svh
//
// A load is written to the node stores when it is taken. A read passes through S_RD
// and S_RESP, which waits until the output register is free. A solve is one shared
// 33x33 multiplier and one shared 64-step restoring divider under a sequencer, with
// the node stores in single-port-read rams. It first scans all nodes once to check
// the setup and once to preset pressures (one node per cycle each), then each sweep
// passes twice over the interior nodes, once to relax and once to measure the defect.
// A non-tumor interior node takes four face weights and a target, each by division
// unless a conductivity or the weight sum is zero, at one quotient bit per cycle.
// Tumor nodes are skipped. The block takes no command while a solve runs.
`include "assert_macros.svh"

module darcy_pressure_sor_solver import dps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  dps_in_if.sink                in_ch,
  dps_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE, S_RD, S_RESP, S_CHK, S_VSCAN, S_ISCAN, S_NODE, S_NB, S_FW_MUL, S_FW_DIV,
    S_FW_FIN, S_AS_ISSUE, S_AS_TAKE, S_WSTORE, S_NORM, S_ACC_ISSUE, S_ACC_TAKE,
    S_TGT, S_T_DIV, S_T_FIN, S_APPLY, S_UPD, S_NEXT
  } state_t;

  // configuration
  logic [5:0]         cx_r, cy_r;
  logic [23:0]        asp_r;
  logic [14:0]        omg_r;
  logic [30:0]        tol_r;
  logic [15:0]        lim_r;
  logic signed [31:0] bp_r, tp_r;

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [15:0] last_sw_r, last_sw_nxt;
  logic [31:0] last_def_r, last_def_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic signed [31:0] out_p_r, out_p_nxt, res_p_r, res_p_nxt;
  logic [1:0]  out_st_r, out_st_nxt, res_st_r, res_st_nxt;
  logic [15:0] out_sw_r, out_sw_nxt;
  logic [31:0] out_def_r, out_def_nxt;
  logic [5:0]  i_r, i_nxt, j_r, j_nxt;
  logic [ADDR_W-1:0] c_r, c_nxt;
  logic [1:0]  k_r, k_nxt;
  logic [15:0] it_r, it_nxt;
  logic        pass_r, pass_nxt;
  logic [31:0] ac_r, ac_nxt;
  logic signed [31:0] pc_r, pc_nxt;
  logic [32:0] s_r, s_nxt;
  logic [39:0] w_r [4];
  logic [39:0] w_nxt [4];
  logic signed [31:0] pn_r [4];
  logic signed [31:0] pn_nxt [4];
  logic [39:0] w_cur_r, w_cur_nxt;
  logic [41:0] diag_r, diag_nxt;
  logic [3:0]  sh_r, sh_nxt;
  logic [30:0] dsum_r, dsum_nxt;
  logic signed [63:0] num_r, num_nxt;
  logic signed [33:0] t_r, t_nxt;
  logic        neg_r, neg_nxt;
  logic [31:0] defect_r, defect_nxt;
  logic [63:0] quo_r, quo_nxt;
  logic [33:0] rem_r, rem_nxt, dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic signed [65:0] mul_p_r, mul_p_nxt;
  logic signed [32:0] mul_a, mul_b;

  // memory ports
  logic        c_we, t_we, p_we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0] c_wdata;
  logic        t_wdata;
  logic signed [31:0] p_wdata;
  logic [31:0] cond_q, press_q;
  logic        tum_q;

  dps_ram #(.WIDTH(32), .DEPTH(NODE_DEPTH)) u_cond_ram (
    .clk, .we(c_we), .waddr, .wdata(c_wdata), .raddr(addr_nxt), .rdata(cond_q)
  );
  dps_ram #(.WIDTH(1), .DEPTH(NODE_DEPTH)) u_tum_ram (
    .clk, .we(t_we), .waddr, .wdata(t_wdata), .raddr(addr_nxt), .rdata(tum_q)
  );
  dps_ram #(.WIDTH(32), .DEPTH(NODE_DEPTH)) u_press_ram (
    .clk, .we(p_we), .waddr, .wdata(p_wdata), .raddr(addr_nxt), .rdata(press_q)
  );

  // shared divider step
  logic [34:0] div_sh, div_rem;
  logic        div_ge;
  assign div_sh  = {rem_r, quo_r[63]};
  assign div_ge  = div_sh >= {1'b0, dvs_r};
  assign div_rem = div_ge ? div_sh - {1'b0, dvs_r} : div_sh;

  assign mul_p_nxt = mul_a * mul_b;

  // derived values
  logic [6:0]  stride;
  logic [ADDR_W-1:0] nb_addr [4];
  logic        ring, cfg_bad, fw_rnd;
  logic [31:0] fw_w;
  logic [39:0] w_shift;
  logic [28:0] ws;
  logic signed [64:0] two_n, mag;
  logic signed [33:0] qv;
  logic signed [34:0] diff;
  logic [34:0] diff_abs;
  logic [31:0] diff_sat;
  logic signed [65:0] upd_sum;
  logic        upd_ovf;
  logic signed [31:0] upd_p;

  assign stride     = {1'b0, cx_r} + 7'd1;
  assign nb_addr[0] = c_r + 12'd1;
  assign nb_addr[1] = c_r - 12'd1;
  assign nb_addr[2] = c_r + ADDR_W'(stride);
  assign nb_addr[3] = c_r - ADDR_W'(stride);
  assign ring       = (i_r == 6'd0) || (i_r == cx_r) || (j_r == 6'd0) || (j_r == cy_r);
  assign cfg_bad    = (cx_r < 6'd2) || (cy_r < 6'd2) || (asp_r == '0) || (omg_r == '0) ||
                      (tol_r == '0) || (lim_r == '0) || (tp_r < bp_r);
  assign fw_rnd     = {rem_r, 1'b0} >= {2'b00, s_r};
  assign fw_w       = {quo_r[30:0], 1'b0} + {31'd0, fw_rnd};
  assign w_shift    = w_r[k_r] >> sh_r;
  assign ws         = w_shift[28:0];
  assign two_n      = $signed({num_r, 1'b0}) + $signed({34'd0, dsum_r});
  assign mag        = two_n[64] ? -two_n : two_n;
  assign qv         = $signed({1'b0, quo_r[32:0]});
  assign diff       = {t_r[33], t_r} - {{3{pc_r[31]}}, pc_r};
  assign diff_abs   = diff[34] ? 35'(-diff) : 35'(diff);
  assign diff_sat   = (diff_abs[34:32] != 3'd0) ? 32'hFFFF_FFFF : diff_abs[31:0];
  assign upd_sum    = ((mul_p_r + 66'sd8192) >>> 14) + $signed({{34{pc_r[31]}}, pc_r});
  assign upd_ovf    = !((&upd_sum[65:31]) || (~|upd_sum[65:31]));
  assign upd_p      = upd_ovf ? (upd_sum[65] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                              : upd_sum[31:0];

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.pressure    = out_p_r;
  assign out_ch.status      = out_st_r;
  assign out_ch.sweeps_used = out_sw_r;
  assign out_ch.max_defect  = out_def_r;

  always_comb begin
    state_nxt = state_r;   addr_nxt = addr_r;     last_sw_nxt = last_sw_r;
    last_def_nxt = last_def_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_p_nxt = out_p_r;   out_st_nxt = out_st_r; out_sw_nxt = out_sw_r;
    out_def_nxt = out_def_r;
    res_p_nxt = res_p_r;   res_st_nxt = res_st_r;
    i_nxt = i_r; j_nxt = j_r; c_nxt = c_r; k_nxt = k_r; it_nxt = it_r; pass_nxt = pass_r;
    ac_nxt = ac_r; pc_nxt = pc_r; s_nxt = s_r; w_nxt = w_r; pn_nxt = pn_r;
    w_cur_nxt = w_cur_r; diag_nxt = diag_r; sh_nxt = sh_r; dsum_nxt = dsum_r;
    num_nxt = num_r; t_nxt = t_r; neg_nxt = neg_r; defect_nxt = defect_r;
    quo_nxt = quo_r; rem_nxt = rem_r; dvs_nxt = dvs_r; cnt_nxt = cnt_r;
    mul_a = '0; mul_b = '0;
    c_we = 1'b0; t_we = 1'b0; p_we = 1'b0; waddr = addr_r;
    c_wdata = in_ch.conductivity; t_wdata = in_ch.tumor_flag;
    p_wdata = tum_q ? tp_r : bp_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.opcode)
            OP_LOAD: begin
              c_we = 1'b1; t_we = 1'b1; waddr = in_ch.node_index;
            end
            OP_SOLVE: state_nxt = S_CHK;
            OP_READ: begin
              addr_nxt = in_ch.node_index; state_nxt = S_RD;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        res_p_nxt = press_q; res_st_nxt = ST_READ; state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1; out_p_nxt = res_p_r; out_st_nxt = res_st_r;
          out_sw_nxt = last_sw_r; out_def_nxt = last_def_r; state_nxt = S_IDLE;
        end
      end
      S_CHK: begin
        res_p_nxt = '0;
        if (cfg_bad) begin
          res_st_nxt = ST_INVALID; last_sw_nxt = '0; last_def_nxt = '0;
          state_nxt = S_RESP;
        end else begin
          i_nxt = '0; j_nxt = '0; addr_nxt = '0; state_nxt = S_VSCAN;
        end
      end
      S_VSCAN: begin
        if ((cond_q == '0) || (ring && tum_q)) begin
          res_st_nxt = ST_INVALID; last_sw_nxt = '0; last_def_nxt = '0;
          state_nxt = S_RESP;
        end else if (i_r == cx_r && j_r == cy_r) begin
          i_nxt = '0; j_nxt = '0; addr_nxt = '0; state_nxt = S_ISCAN;
        end else begin
          addr_nxt = addr_r + 12'd1;
          if (i_r == cx_r) begin
            i_nxt = '0; j_nxt = j_r + 6'd1;
          end else begin
            i_nxt = i_r + 6'd1;
          end
        end
      end
      S_ISCAN: begin
        p_we = 1'b1;
        if (i_r == cx_r && j_r == cy_r) begin
          it_nxt = 16'd1; pass_nxt = 1'b0; defect_nxt = '0;
          i_nxt = 6'd1; j_nxt = 6'd1;
          c_nxt = ADDR_W'(stride) + 12'd1; addr_nxt = ADDR_W'(stride) + 12'd1;
          state_nxt = S_NODE;
        end else begin
          addr_nxt = addr_r + 12'd1;
          if (i_r == cx_r) begin
            i_nxt = '0; j_nxt = j_r + 6'd1;
          end else begin
            i_nxt = i_r + 6'd1;
          end
        end
      end
      S_NODE: begin
        if (tum_q) begin
          state_nxt = S_NEXT;
        end else begin
          ac_nxt = cond_q; pc_nxt = press_q; k_nxt = '0; diag_nxt = '0;
          addr_nxt = nb_addr[0]; state_nxt = S_NB;
        end
      end
      S_NB: begin
        pn_nxt[k_r] = press_q;
        if (cond_q == '0 || ac_r == '0) begin
          w_cur_nxt = '0; state_nxt = S_WSTORE;
        end else begin
          mul_a = {1'b0, ac_r}; mul_b = {1'b0, cond_q};
          s_nxt = {1'b0, ac_r} + {1'b0, cond_q};
          state_nxt = S_FW_MUL;
        end
      end
      S_FW_MUL: begin
        quo_nxt = mul_p_r[63:0]; rem_nxt = '0; dvs_nxt = {1'b0, s_r};
        cnt_nxt = 7'd64; state_nxt = S_FW_DIV;
      end
      S_FW_DIV, S_T_DIV: begin
        rem_nxt = div_rem[33:0]; quo_nxt = {quo_r[62:0], div_ge};
        cnt_nxt = cnt_r - 7'd1;
        if (cnt_r == 7'd1) begin
          state_nxt = (state_r == S_FW_DIV) ? S_FW_FIN : S_T_FIN;
        end
      end
      S_FW_FIN: begin
        w_cur_nxt = {8'd0, fw_w};
        state_nxt = (k_r[1]) ? S_AS_ISSUE : S_WSTORE;
      end
      S_AS_ISSUE: begin
        mul_a = {1'b0, w_cur_r[31:0]}; mul_b = {9'd0, asp_r};
        state_nxt = S_AS_TAKE;
      end
      S_AS_TAKE: begin
        w_cur_nxt = mul_p_r[55:16]; state_nxt = S_WSTORE;
      end
      S_WSTORE: begin
        w_nxt[k_r] = w_cur_r;
        diag_nxt = diag_r + {2'b00, w_cur_r};
        if (k_r == 2'd3) begin
          sh_nxt = '0; state_nxt = S_NORM;
        end else begin
          k_nxt = k_r + 2'd1; addr_nxt = nb_addr[k_r + 2'd1]; state_nxt = S_NB;
        end
      end
      S_NORM: begin
        if (diag_r[41:29] != '0) begin
          diag_nxt = diag_r >> 1; sh_nxt = sh_r + 4'd1;
        end else begin
          k_nxt = '0; num_nxt = '0; dsum_nxt = '0; state_nxt = S_ACC_ISSUE;
        end
      end
      S_ACC_ISSUE: begin
        dsum_nxt = dsum_r + {2'b00, ws};
        mul_a = {4'd0, ws}; mul_b = {pn_r[k_r][31], pn_r[k_r]};
        state_nxt = S_ACC_TAKE;
      end
      S_ACC_TAKE: begin
        num_nxt = num_r + $signed(mul_p_r[63:0]);
        if (k_r == 2'd3) begin
          state_nxt = S_TGT;
        end else begin
          k_nxt = k_r + 2'd1; state_nxt = S_ACC_ISSUE;
        end
      end
      S_TGT: begin
        if (dsum_r == '0) begin
          t_nxt = {{2{pc_r[31]}}, pc_r}; state_nxt = S_APPLY;
        end else begin
          neg_nxt = two_n[64]; quo_nxt = mag[63:0]; rem_nxt = '0;
          dvs_nxt = {2'b00, dsum_r, 1'b0}; cnt_nxt = 7'd64; state_nxt = S_T_DIV;
        end
      end
      S_T_FIN: begin
        t_nxt = neg_r ? -(qv + {33'd0, (rem_r != '0)}) : qv;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (!pass_r) begin
          mul_a = diff[32:0]; mul_b = {18'd0, omg_r}; state_nxt = S_UPD;
        end else begin
          if (diff_sat > defect_r) begin
            defect_nxt = diff_sat;
          end
          state_nxt = S_NEXT;
        end
      end
      S_UPD: begin
        p_we = 1'b1; waddr = c_r; p_wdata = upd_p; state_nxt = S_NEXT;
      end
      S_NEXT: begin
        if (i_r == cx_r - 6'd1 && j_r == cy_r - 6'd1) begin
          i_nxt = 6'd1; j_nxt = 6'd1;
          c_nxt = ADDR_W'(stride) + 12'd1; addr_nxt = ADDR_W'(stride) + 12'd1;
          state_nxt = S_NODE;
          if (!pass_r) begin
            pass_nxt = 1'b1; defect_nxt = '0;
          end else begin
            last_sw_nxt = it_r; last_def_nxt = defect_r;
            if (defect_r <= {1'b0, tol_r}) begin
              res_st_nxt = ST_CONV; state_nxt = S_RESP;
            end else if (it_r == lim_r) begin
              res_st_nxt = ST_NOCONV; state_nxt = S_RESP;
            end else begin
              it_nxt = it_r + 16'd1; pass_nxt = 1'b0;
            end
          end
        end else if (i_r == cx_r - 6'd1) begin
          i_nxt = 6'd1; j_nxt = j_r + 6'd1;
          c_nxt = c_r + 12'd3; addr_nxt = c_r + 12'd3; state_nxt = S_NODE;
        end else begin
          i_nxt = i_r + 6'd1; c_nxt = c_r + 12'd1; addr_nxt = c_r + 12'd1;
          state_nxt = S_NODE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; out_valid_r <= 1'b0;
      last_sw_r <= '0; last_def_r <= '0;
      cx_r <= 6'd63; cy_r <= 6'd63; asp_r <= 24'd65536; omg_r <= 15'd16384;
      tol_r <= 31'd65536; lim_r <= 16'd1000; bp_r <= '0; tp_r <= '0;
    end else begin
      state_r <= state_nxt; out_valid_r <= out_valid_nxt;
      last_sw_r <= last_sw_nxt; last_def_r <= last_def_nxt;
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_CELLS_X:  cx_r  <= cfg_wdata[5:0];
          CFG_CELLS_Y:  cy_r  <= cfg_wdata[5:0];
          CFG_ASPECT:   asp_r <= cfg_wdata[23:0];
          CFG_RELAX:    omg_r <= cfg_wdata[14:0];
          CFG_TOL:      tol_r <= cfg_wdata[30:0];
          CFG_ITER_LIM: lim_r <= cfg_wdata[15:0];
          CFG_BND_P:    bp_r  <= cfg_wdata;
          CFG_TUM_P:    tp_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
    addr_r <= addr_nxt; out_p_r <= out_p_nxt; out_st_r <= out_st_nxt;
    out_sw_r <= out_sw_nxt; out_def_r <= out_def_nxt;
    res_p_r <= res_p_nxt; res_st_r <= res_st_nxt;
    i_r <= i_nxt; j_r <= j_nxt; c_r <= c_nxt; k_r <= k_nxt; it_r <= it_nxt;
    pass_r <= pass_nxt; ac_r <= ac_nxt; pc_r <= pc_nxt; s_r <= s_nxt;
    w_r <= w_nxt; pn_r <= pn_nxt; w_cur_r <= w_cur_nxt; diag_r <= diag_nxt;
    sh_r <= sh_nxt; dsum_r <= dsum_nxt; num_r <= num_nxt; t_r <= t_nxt;
    neg_r <= neg_nxt; defect_r <= defect_nxt;
    quo_r <= quo_nxt; rem_r <= rem_nxt; dvs_r <= dvs_nxt; cnt_r <= cnt_nxt;
    mul_p_r <= mul_p_nxt;
  end

  `DPS_ASSERT(a_busy_no_ready, (state_r != S_IDLE) |-> !in_ch.ready, "ready while busy")
  `DPS_ASSERT(a_solve_p_zero, (out_valid_r && out_st_r != ST_READ) |-> (out_p_r == '0), "solve result carries pressure")
  `DPS_ASSERT(a_div_count, (state_r == S_FW_DIV || state_r == S_T_DIV) |-> (cnt_r != '0), "divider ran past its last step")
  `DPS_ASSERT(a_norm_bound, (state_r == S_ACC_ISSUE) |-> (sh_r <= 4'd13), "weight shift out of range")

endmodule
